FILE: rtl/nrfe_pkg.sv
// Package for the NMEA RMC field extractor.
// Holds the shared character codes, field widths and the emit request type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nrfe_pkg;

   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_M       = 8'h4D;
   localparam logic [7:0] CHAR_C       = 8'h43;
   localparam logic [7:0] CHAR_NL      = 8'h0A;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_A       = 8'h41;

   localparam int LEN_W     = 4;
   localparam int COMMA_W   = 3;
   localparam int HDR_LAST  = 5;

   localparam logic [COMMA_W-1:0] COMMA_MAX    = 3'd7;
   localparam logic [COMMA_W-1:0] COMMA_STATUS = 3'd2;
   localparam logic [COMMA_W-1:0] COMMA_LAT    = 3'd3;
   localparam logic [COMMA_W-1:0] COMMA_LON    = 3'd5;

   typedef struct packed {
      logic             start;
      logic             error;
      logic             fix;
      logic [LEN_W-1:0] lat_len;
      logic [LEN_W-1:0] lon_len;
   } emit_req_type;

endpackage

`default_nettype wire

FILE: rtl/nrfe_char_ram.sv
// Character store for the captured latitude and longitude text.
// One write port and one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module nrfe_char_ram #(
   parameter int DEPTH = 21,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/nrfe_parser.sv
// Sentence parser: header check, comma counting and character capture.
// Writes field characters into the character store and raises emit requests.
// Depends on nrfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nrfe_parser #(
   parameter int BUF_LEN   = 76,
   parameter int LAT_CHARS = 10,
   parameter int LON_CHARS = 11,
   localparam int DEPTH  = LAT_CHARS + LON_CHARS,
   localparam int ADDR_W = $clog2(DEPTH),
   localparam int POS_W  = $clog2(BUF_LEN)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [7:0]           in_byte,
   output logic                      wr_en,
   output logic [ADDR_W-1:0]         wr_addr,
   output logic [7:0]                wr_data,
   output nrfe_pkg::emit_req_type    emit_req
);

   localparam logic [POS_W-1:0] POS_MAX = POS_W'(BUF_LEN - 1);
   localparam logic [POS_W-1:0] POS_HDR = POS_W'(nrfe_pkg::HDR_LAST);
   localparam logic [nrfe_pkg::LEN_W-1:0] LAT_MAX = nrfe_pkg::LEN_W'(LAT_CHARS);
   localparam logic [nrfe_pkg::LEN_W-1:0] LON_MAX = nrfe_pkg::LEN_W'(LON_CHARS);

   logic [POS_W-1:0]            pos_ff, pos_in;
   logic                        hdr_ff, hdr_in;
   logic [nrfe_pkg::COMMA_W-1:0] comma_ff, comma_in;
   logic [7:0]                  status_ff, status_in;
   logic                        seen_ff, seen_in;
   logic [nrfe_pkg::LEN_W-1:0]  lat_len_ff, lat_len_in;
   logic [nrfe_pkg::LEN_W-1:0]  lon_len_ff, lon_len_in;

   logic                        is_dollar;
   logic [POS_W-1:0]            pos_c;
   logic [nrfe_pkg::COMMA_W-1:0] comma_c, comma_t;
   logic [7:0]                  status_c, status_t;
   logic                        seen_c, seen_t;
   logic [nrfe_pkg::LEN_W-1:0]  lat_c, lat_t, lon_c, lon_t;
   logic                        in_hdr, take, lat_wr, lon_wr;

   always_comb begin
      is_dollar = (in_byte == nrfe_pkg::CHAR_DOLLAR);
      pos_c    = is_dollar ? '0 : pos_ff;
      comma_c  = is_dollar ? '0 : comma_ff;
      status_c = is_dollar ? '0 : status_ff;
      seen_c   = is_dollar ? 1'b0 : seen_ff;
      lat_c    = is_dollar ? '0 : lat_len_ff;
      lon_c    = is_dollar ? '0 : lon_len_ff;

      in_hdr = (pos_c <= POS_HDR);
      take   = in_hdr || (hdr_ff && (pos_c < POS_MAX));

      comma_t  = comma_c;
      status_t = status_c;
      seen_t   = seen_c;
      lat_t    = lat_c;
      lon_t    = lon_c;
      lat_wr   = 1'b0;
      lon_wr   = 1'b0;
      if (take) begin
         if (in_byte == nrfe_pkg::CHAR_COMMA) begin
            if (comma_c < nrfe_pkg::COMMA_MAX) begin
               comma_t = comma_c + 1'b1;
            end
         end else if (comma_c == nrfe_pkg::COMMA_STATUS) begin
            if (!seen_c) begin
               status_t = in_byte;
               seen_t   = 1'b1;
            end
         end else if (comma_c == nrfe_pkg::COMMA_LAT) begin
            if (lat_c < LAT_MAX) begin
               lat_wr = 1'b1;
               lat_t  = lat_c + 1'b1;
            end
         end else if (comma_c == nrfe_pkg::COMMA_LON) begin
            if (lon_c < LON_MAX) begin
               lon_wr = 1'b1;
               lon_t  = lon_c + 1'b1;
            end
         end
      end

      wr_en   = in_valid && (lat_wr || lon_wr);
      wr_addr = lat_wr ? ADDR_W'(lat_c) : ADDR_W'(LAT_CHARS + int'(lon_c));
      wr_data = in_byte;

      pos_in     = pos_c;
      hdr_in     = hdr_ff;
      comma_in   = comma_t;
      status_in  = status_t;
      seen_in    = seen_t;
      lat_len_in = lat_t;
      lon_len_in = lon_t;
      emit_req   = '0;

      if (in_hdr) begin
         if (pos_c == '0) begin
            hdr_in = is_dollar;
         end else if (pos_c == POS_W'(4)) begin
            hdr_in = hdr_ff && (in_byte == nrfe_pkg::CHAR_M);
         end else if (pos_c == POS_HDR) begin
            hdr_in = hdr_ff && (in_byte == nrfe_pkg::CHAR_C);
         end
         pos_in = pos_c + 1'b1;
      end else if (hdr_ff) begin
         if (in_byte == nrfe_pkg::CHAR_NL) begin
            emit_req.start   = in_valid;
            emit_req.error   = (comma_t != nrfe_pkg::COMMA_MAX);
            emit_req.fix     = seen_t && (status_t == nrfe_pkg::CHAR_A);
            emit_req.lat_len = lat_t;
            emit_req.lon_len = lon_t;
            pos_in     = '0;
            comma_in   = '0;
            status_in  = '0;
            seen_in    = 1'b0;
            lat_len_in = '0;
            lon_len_in = '0;
         end else if (pos_c < POS_MAX) begin
            pos_in = pos_c + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         hdr_ff     <= 1'b0;
         comma_ff   <= '0;
         status_ff  <= '0;
         seen_ff    <= 1'b0;
         lat_len_ff <= '0;
         lon_len_ff <= '0;
      end else if (in_valid) begin
         pos_ff     <= pos_in;
         hdr_ff     <= hdr_in;
         comma_ff   <= comma_in;
         status_ff  <= status_in;
         seen_ff    <= seen_in;
         lat_len_ff <= lat_len_in;
         lon_len_ff <= lon_len_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/nrfe_emitter.sv
// Result sequencer: reads the character store entry by entry and drives the
// registered result word. Depends on nrfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nrfe_emitter #(
   parameter int LAT_CHARS = 10,
   parameter int LON_CHARS = 11,
   localparam int DEPTH  = LAT_CHARS + LON_CHARS,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire nrfe_pkg::emit_req_type emit_req,
   output logic                        busy,
   output logic                        rd_en,
   output logic [ADDR_W-1:0]           rd_addr,
   input  wire logic [7:0]             rd_data,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output logic                        out_error,
   output logic                        out_fix,
   output logic                        out_sel,
   output logic [3:0]                  out_index,
   output logic [7:0]                  out_value,
   output logic                        out_last
);

   localparam logic [ADDR_W-1:0] LAT_BASE = ADDR_W'(LAT_CHARS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic                        active_ff, active_in;
   logic [ADDR_W-1:0]           iss_ff, iss_in;
   logic                        fix_ff, fix_in;
   logic [nrfe_pkg::LEN_W-1:0]  lat_len_ff, lat_len_in;
   logic [nrfe_pkg::LEN_W-1:0]  lon_len_ff, lon_len_in;

   logic                        pend_ff, pend_in;
   logic                        p_sel_ff, p_sel_in;
   logic [3:0]                  p_idx_ff, p_idx_in;
   logic                        p_hit_ff, p_hit_in;
   logic                        p_last_ff, p_last_in;

   logic                        ov_ff, ov_in;
   logic                        oerr_ff, oerr_in;
   logic                        ofix_ff, ofix_in;
   logic                        osel_ff, osel_in;
   logic [3:0]                  oidx_ff, oidx_in;
   logic [7:0]                  oval_ff, oval_in;
   logic                        olast_ff, olast_in;

   logic                        advance, issue, load, iss_sel;
   logic [3:0]                  iss_idx;

   always_comb begin
      advance = !ov_ff || out_ready;
      issue   = active_ff && (!pend_ff || advance);
      load    = pend_ff && advance;

      iss_sel = (iss_ff >= LAT_BASE);
      iss_idx = iss_sel ? 4'(iss_ff - LAT_BASE) : 4'(iss_ff);

      rd_en   = issue;
      rd_addr = iss_ff;

      active_in  = active_ff;
      iss_in     = iss_ff;
      fix_in     = fix_ff;
      lat_len_in = lat_len_ff;
      lon_len_in = lon_len_ff;
      if (emit_req.start && !emit_req.error) begin
         active_in  = 1'b1;
         iss_in     = '0;
         fix_in     = emit_req.fix;
         lat_len_in = emit_req.lat_len;
         lon_len_in = emit_req.lon_len;
      end else if (issue) begin
         iss_in = iss_ff + 1'b1;
         if (iss_ff == LAST_ADDR) begin
            active_in = 1'b0;
         end
      end

      pend_in   = issue || (pend_ff && !advance);
      p_sel_in  = p_sel_ff;
      p_idx_in  = p_idx_ff;
      p_hit_in  = p_hit_ff;
      p_last_in = p_last_ff;
      if (issue) begin
         p_sel_in  = iss_sel;
         p_idx_in  = iss_idx;
         p_hit_in  = iss_sel ? (iss_idx < lon_len_ff) : (iss_idx < lat_len_ff);
         p_last_in = (iss_ff == LAST_ADDR);
      end

      ov_in    = ov_ff;
      oerr_in  = oerr_ff;
      ofix_in  = ofix_ff;
      osel_in  = osel_ff;
      oidx_in  = oidx_ff;
      oval_in  = oval_ff;
      olast_in = olast_ff;
      if (emit_req.start && emit_req.error) begin
         ov_in    = 1'b1;
         oerr_in  = 1'b1;
         ofix_in  = 1'b0;
         osel_in  = 1'b0;
         oidx_in  = '0;
         oval_in  = '0;
         olast_in = 1'b1;
      end else if (load) begin
         ov_in    = 1'b1;
         oerr_in  = 1'b0;
         ofix_in  = fix_ff;
         osel_in  = p_sel_ff;
         oidx_in  = p_idx_ff;
         oval_in  = p_hit_ff ? rd_data : 8'd0;
         olast_in = p_last_ff;
      end else if (out_ready) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
         ov_ff     <= 1'b0;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
         ov_ff     <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff     <= iss_in;
      fix_ff     <= fix_in;
      lat_len_ff <= lat_len_in;
      lon_len_ff <= lon_len_in;
      p_sel_ff   <= p_sel_in;
      p_idx_ff   <= p_idx_in;
      p_hit_ff   <= p_hit_in;
      p_last_ff  <= p_last_in;
      oerr_ff    <= oerr_in;
      ofix_ff    <= ofix_in;
      osel_ff    <= osel_in;
      oidx_ff    <= oidx_in;
      oval_ff    <= oval_in;
      olast_ff   <= olast_in;
   end

   assign busy      = active_ff || pend_ff || ov_ff;
   assign out_valid = ov_ff;
   assign out_error = oerr_ff;
   assign out_fix   = ofix_ff;
   assign out_sel   = osel_ff;
   assign out_index = oidx_ff;
   assign out_value = oval_ff;
   assign out_last  = olast_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      emit_req.start |=> busy)
      else $error("emit request did not make the sequencer busy");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      ov_ff && olast_ff && out_ready |=> !active_ff && !pend_ff)
      else $error("reads still pending after the final word");

   a_rd_hold: assert property (@(posedge clock) disable iff (reset)
      pend_ff && !advance |=> $stable(rd_data))
      else $error("read data changed while waiting for the output register");

   a_err_alone: assert property (@(posedge clock) disable iff (reset)
      ov_ff && oerr_ff |-> !active_ff && !pend_ff)
      else $error("error word overlaps a character sequence");

endmodule

`default_nettype wire

FILE: rtl/nmea_rmc_field_extractor_unit.sv
// NMEA RMC field extractor, top level.
// Ties the sentence parser, the character store and the result sequencer.
// Depends on nrfe_pkg, nrfe_parser, nrfe_char_ram and nrfe_emitter.
//
// The req_ channel takes one received character per word. Ordinary
// characters are absorbed and produce nothing. A newline that ends an
// accepted RMC sentence produces either one error word (fewer than seven
// commas), valid on the next cycle, or LAT_CHARS + LON_CHARS character
// words, latitude first, the first passing through the sequencer's active,
// pending and output registers and the rest following one per cycle while
// rsp_tready stays high. rsp_tlast marks the final word of the sentence.
// The character store has one read port, which sets the rate of one result
// word per cycle.
// req_tready is low from the newline until the final word has been taken.
// When rsp_tready is low the current word holds and the sequencer waits;
// nothing is lost. Reset clears all sentence state and drops any word in
// flight; the character store needs no clearing, since entries at or past
// the captured field lengths read as zero.
`timescale 1ns / 1ps
`default_nettype none

module nmea_rmc_field_extractor_unit #(
   parameter int BUF_LEN   = 76,
   parameter int LAT_CHARS = 10,
   parameter int LON_CHARS = 11
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [0] fix_valid, [4:1] char_index,
                                         // [12:5] char_value, [15:13] zero
   output logic [1:0]       rsp_tuser,   // [0] parse_error, [1] field_select
   output logic             rsp_tlast    // last
);

   localparam int DEPTH  = LAT_CHARS + LON_CHARS;
   localparam int ADDR_W = $clog2(DEPTH);

   logic                   busy;
   logic                   in_valid;
   logic                   wr_en, rd_en;
   logic [ADDR_W-1:0]      wr_addr, rd_addr;
   logic [7:0]             wr_data, rd_data;
   nrfe_pkg::emit_req_type emit_req;
   logic                   out_error, out_fix, out_sel;
   logic [3:0]             out_index;
   logic [7:0]             out_value;

   assign req_tready = !busy;
   assign in_valid   = req_tvalid && !busy;

   nrfe_parser #(
      .BUF_LEN   (BUF_LEN),
      .LAT_CHARS (LAT_CHARS),
      .LON_CHARS (LON_CHARS)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_byte  (req_tdata),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .emit_req (emit_req)
   );

   nrfe_char_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nrfe_emitter #(
      .LAT_CHARS (LAT_CHARS),
      .LON_CHARS (LON_CHARS)
   ) u_emitter (
      .clock     (clock),
      .reset     (reset),
      .emit_req  (emit_req),
      .busy      (busy),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_error (out_error),
      .out_fix   (out_fix),
      .out_sel   (out_sel),
      .out_index (out_index),
      .out_value (out_value),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, out_value, out_index, out_fix};
   assign rsp_tuser = {out_sel, out_error};

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for nmea_rmc_field_extractor_unit.
// Drives received characters, predicts the result words and compares them field by field.
// Depends on nrfe_pkg and the RTL of nmea_rmc_field_extractor_unit.
`timescale 1ns / 1ps

module testbench;

   localparam int BUF_LEN      = 76;
   localparam int LAT_CHARS    = 10;
   localparam int LON_CHARS    = 11;
   localparam int HDR_M_POS    = 4;
   localparam int RANDOM_CHARS = 300;
   localparam int HOLD_AT      = 80;
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_AFTER  = 300;
   localparam int DRAIN_CYCLES = 2 * (LAT_CHARS + LON_CHARS + 2);
   localparam int STALL_LIMIT  = 2000;
   localparam int PRINT_LIMIT  = 50;
   localparam bit SEL_LAT      = 1'b0;
   localparam bit SEL_LON      = 1'b1;

   typedef struct packed {
      logic       parse_error;
      logic       fix_valid;
      logic       field_select;
      logic [3:0] char_index;
      logic [7:0] char_value;
      logic       last;
   } rmc_word_type;

   typedef struct packed {
      logic [7:0]   rx;
      logic         typed;
      rmc_word_type word;
   } dir_row_type;

   localparam rmc_word_type NO_WORD    = '0;
   localparam rmc_word_type ERROR_WORD = '{parse_error: 1'b1, last: 1'b1, default: '0};

   // A stray character and a newline before any sentence, a sentence with no
   // commas, then a full sentence with status 'A' and extreme character values.
   localparam dir_row_type DIRECTED_ROWS [26] = '{
      '{"x", 1'b0, NO_WORD}, '{nrfe_pkg::CHAR_NL, 1'b0, NO_WORD},
      '{nrfe_pkg::CHAR_DOLLAR, 1'b0, NO_WORD}, '{"G", 1'b0, NO_WORD},
      '{"P", 1'b0, NO_WORD}, '{"R", 1'b0, NO_WORD},
      '{nrfe_pkg::CHAR_M, 1'b0, NO_WORD}, '{nrfe_pkg::CHAR_C, 1'b0, NO_WORD},
      '{nrfe_pkg::CHAR_NL, 1'b1, ERROR_WORD},
      '{nrfe_pkg::CHAR_DOLLAR, 1'b0, NO_WORD}, '{"G", 1'b0, NO_WORD},
      '{"N", 1'b0, NO_WORD}, '{"R", 1'b0, NO_WORD},
      '{nrfe_pkg::CHAR_M, 1'b0, NO_WORD}, '{nrfe_pkg::CHAR_C, 1'b0, NO_WORD},
      '{nrfe_pkg::CHAR_COMMA, 1'b0, NO_WORD}, '{nrfe_pkg::CHAR_COMMA, 1'b0, NO_WORD},
      '{nrfe_pkg::CHAR_A, 1'b0, NO_WORD}, '{nrfe_pkg::CHAR_COMMA, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD}, '{nrfe_pkg::CHAR_COMMA, 1'b0, NO_WORD},
      '{nrfe_pkg::CHAR_COMMA, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
      '{nrfe_pkg::CHAR_COMMA, 1'b0, NO_WORD}, '{nrfe_pkg::CHAR_COMMA, 1'b0, NO_WORD},
      '{nrfe_pkg::CHAR_NL, 1'b0, NO_WORD}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   logic [6:0]  sentence_pos;
   logic        header_good;
   logic [2:0]  comma_total;
   logic [7:0]  status_byte;
   logic        status_held;
   logic [7:0]  lat_text [LAT_CHARS];
   logic [3:0]  lat_count;
   logic [7:0]  lon_text [LON_CHARS];
   logic [3:0]  lon_count;

   rmc_word_type expected_words [$];
   logic [7:0]   char_plan [$];
   int           bytes_sent;
   int           words_checked;
   int           sentences_done;
   int           error_words;
   int           mismatches;
   int           stall_cycles;

   nmea_rmc_field_extractor_unit #(
      .BUF_LEN   (BUF_LEN),
      .LAT_CHARS (LAT_CHARS),
      .LON_CHARS (LON_CHARS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void forget_sentence();
      comma_total = '0;
      status_byte = '0;
      status_held = 1'b0;
      foreach (lat_text[i]) lat_text[i] = '0;
      foreach (lon_text[i]) lon_text[i] = '0;
      lat_count = '0;
      lon_count = '0;
   endfunction

   function automatic void take_field_char(input logic [7:0] rx);
      if (rx == nrfe_pkg::CHAR_COMMA) begin
         if (comma_total != nrfe_pkg::COMMA_MAX) comma_total++;
         return;
      end
      case (comma_total)
         nrfe_pkg::COMMA_STATUS: begin
            if (!status_held) begin
               status_byte = rx;
               status_held = 1'b1;
            end
         end
         nrfe_pkg::COMMA_LAT: begin
            if (lat_count < LAT_CHARS) begin
               lat_text[lat_count] = rx;
               lat_count++;
            end
         end
         nrfe_pkg::COMMA_LON: begin
            if (lon_count < LON_CHARS) begin
               lon_text[lon_count] = rx;
               lon_count++;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void predict_char(input logic [7:0] rx);
      logic         fix;
      rmc_word_type w;
      if (rx == nrfe_pkg::CHAR_DOLLAR) begin
         sentence_pos = '0;
         forget_sentence();
      end
      if (sentence_pos <= nrfe_pkg::HDR_LAST) begin
         if (sentence_pos == 0) begin
            header_good = (rx == nrfe_pkg::CHAR_DOLLAR);
         end else if (sentence_pos == HDR_M_POS) begin
            header_good = header_good && (rx == nrfe_pkg::CHAR_M);
         end else if (sentence_pos == nrfe_pkg::HDR_LAST) begin
            header_good = header_good && (rx == nrfe_pkg::CHAR_C);
         end
         take_field_char(rx);
         sentence_pos++;
         return;
      end
      if (!header_good) return;
      if (sentence_pos < BUF_LEN - 1) take_field_char(rx);
      if (rx == nrfe_pkg::CHAR_NL) begin
         if (comma_total != nrfe_pkg::COMMA_MAX) begin
            expected_words.push_back(ERROR_WORD);
            error_words++;
         end else begin
            fix = status_held && (status_byte == nrfe_pkg::CHAR_A);
            for (int i = 0; i < LAT_CHARS; i++) begin
               w = '0;
               w.fix_valid    = fix;
               w.field_select = SEL_LAT;
               w.char_index   = 4'(i);
               w.char_value   = (i < lat_count) ? lat_text[i] : 8'h00;
               expected_words.push_back(w);
            end
            for (int i = 0; i < LON_CHARS; i++) begin
               w = '0;
               w.fix_valid    = fix;
               w.field_select = SEL_LON;
               w.char_index   = 4'(i);
               w.char_value   = (i < lon_count) ? lon_text[i] : 8'h00;
               w.last         = (i == LON_CHARS - 1);
               expected_words.push_back(w);
            end
         end
         sentences_done++;
         sentence_pos = '0;
         forget_sentence();
         return;
      end
      if (sentence_pos < BUF_LEN - 1) sentence_pos++;
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == nrfe_pkg::CHAR_DOLLAR || c == nrfe_pkg::CHAR_COMMA ||
             c == nrfe_pkg::CHAR_NL);
      return c;
   endfunction

   // Mostly RMC sentences with random field contents; some noise, some bad
   // headers, some short sentences, overlong fields and overfull buffers.
   function automatic void plan_sentence();
      int kind;
      int commas;
      int flen;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         repeat ($urandom_range(1, 16)) char_plan.push_back(8'($urandom_range(0, 255)));
         return;
      end
      char_plan.push_back(nrfe_pkg::CHAR_DOLLAR);
      for (int i = 1; i <= nrfe_pkg::HDR_LAST; i++) begin
         if (kind == 1) char_plan.push_back(plain_char());
         else if (i == HDR_M_POS) char_plan.push_back(nrfe_pkg::CHAR_M);
         else if (i == nrfe_pkg::HDR_LAST) char_plan.push_back(nrfe_pkg::CHAR_C);
         else if ($urandom_range(0, 7) == 0)
            char_plan.push_back($urandom_range(0, 1) ? nrfe_pkg::CHAR_NL
                                                     : nrfe_pkg::CHAR_COMMA);
         else char_plan.push_back(8'("A" + $urandom_range(0, 25)));
      end
      commas = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : $urandom_range(7, 12);
      for (int k = 1; k <= commas; k++) begin
         char_plan.push_back(nrfe_pkg::CHAR_COMMA);
         if (k == nrfe_pkg::COMMA_STATUS) begin
            case ($urandom_range(0, 3))
               0: char_plan.push_back(nrfe_pkg::CHAR_A);
               1: char_plan.push_back("V");
               2: ;
               default: char_plan.push_back(plain_char());
            endcase
            if ($urandom_range(0, 2) == 0) char_plan.push_back(plain_char());
         end else begin
            flen = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 4);
            repeat (flen) char_plan.push_back(plain_char());
         end
      end
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(60, 90)) char_plan.push_back(plain_char());
      char_plan.push_back(nrfe_pkg::CHAR_NL);
   endfunction

   task automatic send_char(input logic [7:0] rx, input logic typed,
                            input rmc_word_type typed_word);
      int queued;
      if (bytes_sent < QUIET_AFTER && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      queued = expected_words.size();
      predict_char(rx);
      if (typed) begin
         while (expected_words.size() > queued) void'(expected_words.pop_back());
         expected_words.push_back(typed_word);
      end
      bytes_sent++;
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      if (mismatches < PRINT_LIMIT)
         $display("%0t: word %0d, %s: got %0h, expected %0h", $time, words_checked, what,
                  got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rmc_word_type got;
      rmc_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.parse_error  = rsp_tuser[0];
         got.field_select = rsp_tuser[1];
         got.fix_valid    = rsp_tdata[0];
         got.char_index   = rsp_tdata[4:1];
         got.char_value   = rsp_tdata[12:5];
         got.last         = rsp_tlast;
         if (expected_words.size() == 0) begin
            report_mismatch("word with nothing expected", got.char_value, 8'h00);
         end else begin
            want = expected_words.pop_front();
            if (got.parse_error !== want.parse_error)
               report_mismatch("parse_error", 8'(got.parse_error), 8'(want.parse_error));
            if (got.fix_valid !== want.fix_valid)
               report_mismatch("fix_valid", 8'(got.fix_valid), 8'(want.fix_valid));
            if (got.field_select !== want.field_select)
               report_mismatch("field_select", 8'(got.field_select),
                               8'(want.field_select));
            if (got.char_index !== want.char_index)
               report_mismatch("char_index", 8'(got.char_index), 8'(want.char_index));
            if (got.char_value !== want.char_value)
               report_mismatch("char_value", got.char_value, want.char_value);
            if (got.last !== want.last)
               report_mismatch("last", 8'(got.last), 8'(want.last));
            if (rsp_tdata[15:13] !== 3'b000)
               report_mismatch("tdata padding", 8'(rsp_tdata[15:13]), 8'h00);
         end
         words_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin : receiver
      logic hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && bytes_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (bytes_sent < QUIET_AFTER && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int random_sent;
      random_sent = 0;
      bytes_sent = 0;
      words_checked = 0;
      sentences_done = 0;
      error_words = 0;
      mismatches = 0;
      stall_cycles = 0;
      sentence_pos = '0;
      header_good = 1'b0;
      forget_sentence();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED_ROWS[i])
         send_char(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].word);
      while (random_sent < RANDOM_CHARS) begin
         plan_sentence();
         while (char_plan.size() != 0) begin
            send_char(char_plan.pop_front(), 1'b0, NO_WORD);
            random_sent++;
         end
      end
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d characters (%0d directed), %0d sentences closed, %0d error words.",
               bytes_sent, $size(DIRECTED_ROWS), sentences_done, error_words);
      $display("Checked %0d result words; receiver stalled %0d cycles once to back up input.",
               words_checked, HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/nrfe_pkg.sv
rtl/nrfe_char_ram.sv
rtl/nrfe_parser.sv
rtl/nrfe_emitter.sv
rtl/nmea_rmc_field_extractor_unit.sv
tb/sv/testbench.sv
